[sv/driveline_spring_damper_joint_macros.svh]
// Assertion macros used by the checker of the driveline spring-damper joint.
`ifndef DRIVELINE_SPRING_DAMPER_JOINT_MACROS_SVH
`define DRIVELINE_SPRING_DAMPER_JOINT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DSDJ_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DSDJ_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/dsdj_pkg.sv]
// Types, constants, microcode table and arithmetic helpers of the spring-damper joint.
`default_nettype none

package dsdj_pkg;

  localparam int FracBits = 16;
  localparam int ProdW    = 65;   // signed 33 x signed 32 product
  localparam int AccW     = 66;   // sum of two products plus headroom
  localparam int PcW      = 4;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_SPRING_GAIN   = 3'd0,
    CFG_DAMPING_GAIN  = 3'd1,
    CFG_INVERSE_RATIO = 3'd2,
    CFG_HALF_TIMESTEP = 3'd3,
    CFG_DIFF_MODE     = 3'd4
  } cfg_reg_t;

  // Operand pair presented to the shared multiplier.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_SPEED_RATIO,
    MUL_DAMP_REL,
    MUL_HT_SUM,
    MUL_SPRING_ANGLE,
    MUL_TORQUE_RATIO
  } mul_sel_t;

  // Datapath operation of one step.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_REL,
    OP_SUM,
    OP_ACC_LOAD,
    OP_ANGLE,
    OP_ACC_ADD,
    OP_TORQUE,
    OP_REACT,
    OP_CLEAR
  } dp_op_t;

  // One control word of the microprogram.
  typedef struct packed {
    mul_sel_t        mul;
    dp_op_t          op;
    logic            jump_if_off;
    logic [PcW-1:0]  target;
    logic            done;
  } ucode_t;

  localparam logic [PcW-1:0] StepClear = 4'd10;

  // Microprogram: enabled ticks run steps 0 to 9, disabled ticks jump to the clear step.
  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t w;
    w = '{mul: MUL_NONE, op: OP_NOP, jump_if_off: 1'b0, target: '0, done: 1'b0};
    unique case (pc)
      4'd0:  begin
        w.mul         = MUL_SPEED_RATIO;
        w.jump_if_off = 1'b1;
        w.target      = StepClear;
      end
      4'd1:  w.op = OP_REL;
      4'd2:  begin
        w.mul = MUL_DAMP_REL;
        w.op  = OP_SUM;
      end
      4'd3:  begin
        w.mul = MUL_HT_SUM;
        w.op  = OP_ACC_LOAD;
      end
      4'd4:  w.op  = OP_ANGLE;
      4'd5:  w.mul = MUL_SPRING_ANGLE;
      4'd6:  w.op  = OP_ACC_ADD;
      4'd7:  w.op  = OP_TORQUE;
      4'd8:  w.mul = MUL_TORQUE_RATIO;
      4'd9:  begin
        w.op   = OP_REACT;
        w.done = 1'b1;
      end
      4'd10: begin
        w.op   = OP_CLEAR;
        w.done = 1'b1;
      end
      default: w.done = 1'b1;
    endcase
    return w;
  endfunction

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] x);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = {{(AccW-31){1'b0}}, {31{1'b1}}};
    lo = {{(AccW-31){1'b1}}, {31{1'b0}}};
    if (x > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

endpackage

`default_nettype wire

[sv/driveline_spring_damper_joint.sv]
// Driveline spring-damper joint: microcoded sequencer around one shared multiplier.
//
// One input transfer is one physics tick. An enabled tick runs a ten-step microprogram
// after the accepting edge, and the next tick is taken only once it ends; a disabled
// tick runs the first step and then jumps to the clearing step. The sequence is made
// this long by the single shared 33 x 32 bit multiplier, whose products
// form a dependent chain (relative speed, twist angle, spring-damper torque, reaction
// torque), each product registered before it is used. The result sits in an output
// register, so a new tick is accepted while the previous result still waits to be
// taken; the sequencer holds on its last step only if that register is still full.
// Configuration writes are always accepted and must be made while the block is idle.
`default_nettype none

module driveline_spring_damper_joint
  import dsdj_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Input ticks.
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // in_tdata: input_shaft_speed [31:0], output_speed_a [63:32], output_speed_b [95:64]
  input  wire logic [95:0]  in_tdata,
  // in_tuser: joint_enabled [0]
  input  wire logic         in_tuser,
  // Results.
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_tdata: input_reaction_torque [31:0], output_torque_a [63:32],
  //            output_torque_b [95:64], twist_angle_out [127:96]
  output logic [127:0]      out_tdata,
  // Configuration writes.
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  // Configuration registers.
  logic [30:0] spring_r, damp_r, ratio_r;
  logic [15:0] ht_r;
  logic        diff_r;

  // Captured tick.
  logic               en_r;
  logic signed [31:0] speed_in_r, speed_a_r, speed_b_r;

  // Datapath registers.
  logic signed [31:0]      rel_r, prev_r, angle_r, torque_r;
  logic signed [32:0]      sum_r;
  logic signed [AccW-1:0]  acc_r;
  logic signed [ProdW-1:0] prod_r;

  // Sequencer and output.
  logic            busy_r;
  logic [PcW-1:0]  pc_r;
  logic            out_valid_r;
  logic [127:0]    out_data_r;

  ucode_t cw;
  logic   in_xfer, advance;

  assign cw        = ucode_rom(pc_r);
  assign in_tready = !busy_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign advance   = busy_r && !(cw.done && out_valid_r && !out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spring_r <= 31'd65536000;
      damp_r   <= 31'd0;
      ratio_r  <= 31'd65536;
      ht_r     <= 16'd328;
      diff_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SPRING_GAIN:   spring_r <= cfg_data[30:0];
        CFG_DAMPING_GAIN:  damp_r   <= cfg_data[30:0];
        CFG_INVERSE_RATIO: ratio_r  <= cfg_data[30:0];
        CFG_HALF_TIMESTEP: ht_r     <= cfg_data[15:0];
        CFG_DIFF_MODE:     diff_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Capture the tick on its transfer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      en_r       <= in_tuser;
      speed_in_r <= $signed(in_tdata[31:0]);
      speed_a_r  <= $signed(in_tdata[63:32]);
      speed_b_r  <= $signed(in_tdata[95:64]);
    end
  end

  // Shared multiplier operand selection.
  logic signed [32:0]      mul_a;
  logic signed [31:0]      mul_b;
  logic signed [ProdW-1:0] prod_nxt;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cw.mul)
      MUL_SPEED_RATIO: begin
        mul_a = {speed_in_r[31], speed_in_r};
        mul_b = $signed({1'b0, ratio_r});
      end
      MUL_DAMP_REL: begin
        mul_a = {rel_r[31], rel_r};
        mul_b = $signed({1'b0, damp_r});
      end
      MUL_HT_SUM: begin
        mul_a = sum_r;
        mul_b = $signed({16'd0, ht_r});
      end
      MUL_SPRING_ANGLE: begin
        mul_a = {angle_r[31], angle_r};
        mul_b = $signed({1'b0, spring_r});
      end
      MUL_TORQUE_RATIO: begin
        mul_a = {torque_r[31], torque_r};
        mul_b = $signed({1'b0, ratio_r});
      end
      default: ;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (advance && cw.mul != MUL_NONE) begin
      prod_r <= prod_nxt;
    end
  end

  // Datapath results of each operation.
  logic signed [32:0]     pair_sum;
  logic signed [31:0]     target;
  logic signed [AccW-1:0] prod_ext, prod_q, rel_wide, angle_wide, neg_prod;
  logic signed [31:0]     rel_nxt, angle_nxt, torque_nxt, react_nxt, half_torque;
  logic signed [32:0]     sum_nxt;

  always_comb begin
    pair_sum    = {speed_a_r[31], speed_a_r} + {speed_b_r[31], speed_b_r};
    target      = diff_r ? pair_sum[32:1] : speed_a_r;
    prod_ext    = {prod_r[ProdW-1], prod_r};
    prod_q      = $signed({{(AccW-ProdW+FracBits){prod_r[ProdW-1]}},
                           prod_r[ProdW-1:FracBits]});
    rel_wide    = prod_q - $signed({{(AccW-32){target[31]}}, target});
    rel_nxt     = sat32(rel_wide);
    sum_nxt     = {prev_r[31], prev_r} + {rel_r[31], rel_r};
    angle_wide  = $signed({{(AccW-32){angle_r[31]}}, angle_r}) + prod_q;
    angle_nxt   = sat32(angle_wide);
    torque_nxt  = sat32($signed({{FracBits{acc_r[AccW-1]}}, acc_r[AccW-1:FracBits]}));
    neg_prod    = -prod_ext;
    react_nxt   = sat32($signed({{FracBits{neg_prod[AccW-1]}},
                                 neg_prod[AccW-1:FracBits]}));
    half_torque = {torque_r[31], torque_r[31:1]};
  end

  // Datapath state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rel_r   <= '0;
      angle_r <= '0;
    end else if (advance) begin
      unique case (cw.op)
        OP_REL: begin
          prev_r <= rel_r;
          rel_r  <= rel_nxt;
        end
        OP_SUM:      sum_r    <= sum_nxt;
        OP_ACC_LOAD: acc_r    <= prod_ext;
        OP_ANGLE:    angle_r  <= angle_nxt;
        OP_ACC_ADD:  acc_r    <= acc_r + prod_ext;
        OP_TORQUE:   torque_r <= torque_nxt;
        OP_CLEAR:    angle_r  <= '0;
        default: ;
      endcase
    end
  end

  // Step counter with the conditional jump for disabled ticks.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else if (in_xfer) begin
      busy_r <= 1'b1;
      pc_r   <= '0;
    end else if (advance) begin
      priority if (cw.jump_if_off && !en_r) begin
        pc_r <= cw.target;
      end else if (cw.done) begin
        busy_r <= 1'b0;
      end else begin
        pc_r <= pc_r + 4'd1;
      end
    end
  end

  // Output register: loaded on the last step, emptied by a transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && cw.done) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && cw.done) begin
      if (cw.op == OP_REACT) begin
        out_data_r <= {angle_r,
                       diff_r ? half_torque : 32'sd0,
                       diff_r ? half_torque : torque_r,
                       react_nxt};
      end else begin
        out_data_r <= '0;
      end
    end
  end

endmodule

`default_nettype wire

[sv/dsdj_checker.sv]
// Port-level checker for the spring-damper joint, bound to the top level.
`default_nettype none
`include "driveline_spring_damper_joint_macros.svh"

module dsdj_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata
);

  // Ticks accepted whose result has not yet been transferred.
  logic [1:0] pending_r;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending_r <= pending_r + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pending_r <= pending_r - 2'd1;
    end
  end

  `DSDJ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "Stalled result changed or vanished.")
  `DSDJ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_xfer, !in_tready, "Input accepted again while a tick is in work.")
  `DSDJ_ASSERT_SAME(a_no_orphan_result, clk, rst_n, out_xfer, pending_r != 2'd0, "Result transferred without an accepted tick.")
  `DSDJ_ASSERT_SAME(a_pending_bound, clk, rst_n, 1'b1, pending_r <= 2'd2, "More than two ticks outstanding.")

endmodule

bind driveline_spring_damper_joint dsdj_checker u_dsdj_checker (.*);

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the driveline spring-damper joint with its own tick predictor.
module testbench
  import dsdj_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 500000;
  localparam int TicksPerPhase = 185;
  localparam int RandomPhases = 10;
  localparam int SettleCycles = 16;
  localparam int ReportLimit = 10;
  localparam logic [2:0] CfgIndexSpare = 3'd5;
  localparam logic signed [65:0] S32Max = 66'sd2147483647;
  localparam logic signed [65:0] S32Min = -66'sd2147483648;

  // One physics tick as presented on the input stream.
  typedef struct packed {
    logic              enabled;
    logic signed [31:0] shaft_speed;
    logic signed [31:0] speed_a;
    logic signed [31:0] speed_b;
  } joint_tick_t;

  // Torques and angle returned for one tick.
  typedef struct packed {
    logic signed [31:0] reaction;
    logic signed [31:0] torque_a;
    logic signed [31:0] torque_b;
    logic signed [31:0] twist;
  } joint_torques_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [95:0]  in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  // Predictor copy of the registers and the joint state.
  logic [30:0]        k_spring = 31'd65536000;
  logic [30:0]        k_damping = 31'd0;
  logic [30:0]        k_inverse_ratio = 31'd65536;
  logic [15:0]        k_half_step = 16'd328;
  logic               k_diff_mode = 1'b0;
  logic signed [31:0] twist_q = '0;
  logic signed [31:0] rel_q = '0;

  joint_tick_t    tick_q[$];
  joint_torques_t result_q[$];
  joint_tick_t    tx_tick;
  int             tx_gap;
  int             rx_wait;
  bit             tx_calm;
  bit             rx_calm;
  int             errors = 0;
  int unsigned    cycle_count = 0;

  driveline_spring_damper_joint u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Clock with an 8 ns period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Run guard against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic signed [31:0] clamp_s32(input logic signed [65:0] x);
    if (x > S32Max) begin
      return 32'sh7FFF_FFFF;
    end
    if (x < S32Min) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

  // Advance the joint by one tick and return the torques it should produce.
  function automatic joint_torques_t predict_tick(input joint_tick_t t);
    joint_torques_t     r;
    logic signed [65:0] ratio_w, spring_w, damp_w, step_w;
    logic signed [65:0] shaft_w, a_w, b_w, target_w, prev_w, rel_w, twist_w, torque_w;
    logic signed [31:0] torque;
    r = '0;
    if (!t.enabled) begin
      twist_q = '0;
      return r;
    end
    ratio_w  = {35'd0, k_inverse_ratio};
    spring_w = {35'd0, k_spring};
    damp_w   = {35'd0, k_damping};
    step_w   = {50'd0, k_half_step};
    shaft_w  = $signed(t.shaft_speed);
    a_w      = $signed(t.speed_a);
    b_w      = $signed(t.speed_b);
    target_w = k_diff_mode ? ((a_w + b_w) >>> 1) : a_w;
    prev_w   = $signed(rel_q);

    // Relative speed, then trapezoidal update of the twist angle.
    rel_q   = clamp_s32(((shaft_w * ratio_w) >>> FracBits) - target_w);
    rel_w   = $signed(rel_q);
    twist_w = $signed(twist_q);
    twist_q = clamp_s32(twist_w + ((step_w * (prev_w + rel_w)) >>> FracBits));
    twist_w = $signed(twist_q);

    // Spring-damper torque and the reaction seen by the input shaft.
    torque   = clamp_s32((spring_w * twist_w + damp_w * rel_w) >>> FracBits);
    torque_w = $signed(torque);
    r.reaction = clamp_s32((-(torque_w * ratio_w)) >>> FracBits);
    if (k_diff_mode) begin
      r.torque_a = torque >>> 1;
      r.torque_b = torque >>> 1;
    end else begin
      r.torque_a = torque;
      r.torque_b = '0;
    end
    r.twist = twist_q;
    return r;
  endfunction

  function automatic joint_tick_t make_tick(input logic en, input logic [31:0] shaft,
                                            input logic [31:0] a, input logic [31:0] b);
    joint_tick_t t;
    t.enabled     = en;
    t.shaft_speed = shaft;
    t.speed_a     = a;
    t.speed_b     = b;
    return t;
  endfunction

  // Speeds: mostly moderate, some full range, some at the ends of the range or at zero.
  function automatic logic [31:0] rand_speed();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3, 4: return $urandom;
      default: return $signed($urandom) >>> $urandom_range(8, 20);
    endcase
  endfunction

  function automatic joint_tick_t rand_tick();
    return make_tick($urandom_range(0, 15) != 0, rand_speed(), rand_speed(), rand_speed());
  endfunction

  // A 31-bit gain, with bit 31 random so the register masking is exercised.
  function automatic logic [31:0] rand_gain();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = 32'd0;
      1: v = 32'h7FFF_FFFF;
      2: v = $urandom_range(0, 262144);
      3: v = $urandom;
      default: v = $urandom_range(1, 2000) << 16;
    endcase
    v[31] = $urandom_range(0, 1);
    return v;
  endfunction

  function automatic logic [31:0] rand_half_step();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 3))
      0: v[15:0] = 16'd0;
      1: v[15:0] = 16'hFFFF;
      2: v[15:0] = $urandom_range(1, 1000);
      default: ;
    endcase
    return v;
  endfunction

  // Input driver: one transfer per queued tick, random gap after each transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        result_q.push_back(predict_tick(tx_tick));
        tx_gap = tx_calm ? 0 : $urandom_range(0, 7);
      end
      if (in_tvalid && !in_tready) begin
        // Hold the current tick until it is taken.
      end else if (tx_gap != 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (tick_q.size() != 0) begin
        tx_tick = tick_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {tx_tick.speed_b, tx_tick.speed_a, tx_tick.shaft_speed};
        in_tuser  <= tx_tick.enabled;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= ReportLimit) begin
        $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
    end
  endtask

  task automatic check_result(input logic [127:0] data);
    joint_torques_t want;
    if (result_q.size() == 0) begin
      errors++;
      if (errors <= ReportLimit) begin
        $display("unexpected result %h", data);
      end
      return;
    end
    want = result_q.pop_front();
    compare_field("input_reaction_torque", want.reaction, data[31:0]);
    compare_field("output_torque_a", want.torque_a, data[63:32]);
    compare_field("output_torque_b", want.torque_b, data[95:64]);
    compare_field("twist_angle_out", want.twist, data[127:96]);
  endtask

  // Result monitor: each transfer is checked; the stall counts down while a result waits.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_result(out_tdata);
        rx_wait = rx_calm ? 0 : $urandom_range(0, 7);
      end else if (out_tvalid && rx_wait != 0) begin
        rx_wait--;
      end
      out_tready <= (rx_wait == 0);
    end
  end

  // One register write; the predictor copy is updated on the transfer.
  task automatic cfg_write(input logic [2:0] index, input logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      CFG_SPRING_GAIN:   k_spring = data[30:0];
      CFG_DAMPING_GAIN:  k_damping = data[30:0];
      CFG_INVERSE_RATIO: k_inverse_ratio = data[30:0];
      CFG_HALF_TIMESTEP: k_half_step = data[15:0];
      CFG_DIFF_MODE:     k_diff_mode = data[0];
      default: ;
    endcase
  endtask

  // Wait until every tick has been taken and every result has come back.
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (tick_q.size() != 0 || in_tvalid || result_q.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, single output: a disabled first tick, saturating speeds,
    // growth of the angle and a disabled tick that clears it.
    @(negedge clk);
    tick_q.push_back(make_tick(1'b0, 32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF));
    tick_q.push_back(make_tick(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
    tick_q.push_back(make_tick(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
    tick_q.push_back(make_tick(1'b1, 32'h0, 32'h0, 32'h0));
    tick_q.push_back(make_tick(1'b1, 32'h0001_0000, 32'h0, 32'h7FFF_FFFF));
    tick_q.push_back(make_tick(1'b1, 32'h0001_0000, 32'h0, 32'h8000_0000));
    tick_q.push_back(make_tick(1'b0, 32'h0001_0000, 32'h0, 32'h0));
    tick_q.push_back(make_tick(1'b1, 32'hFFFF_FFFF, 32'h0, 32'h0));
    tick_q.push_back(make_tick(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0));
    wait_idle();

    // Every register at its top value (bits above each field set), differential.
    cfg_write(CFG_SPRING_GAIN, 32'hFFFF_FFFF);
    cfg_write(CFG_DAMPING_GAIN, 32'hFFFF_FFFF);
    cfg_write(CFG_INVERSE_RATIO, 32'hFFFF_FFFF);
    cfg_write(CFG_HALF_TIMESTEP, 32'hFFFF_FFFF);
    cfg_write(CFG_DIFF_MODE, 32'hFFFF_FFFF);
    @(negedge clk);
    tick_q.push_back(make_tick(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    tick_q.push_back(make_tick(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    tick_q.push_back(make_tick(1'b1, 32'h0, 32'hFFFF_FFFF, 32'h0));
    tick_q.push_back(make_tick(1'b1, 32'h0000_0001, 32'h0000_0003, 32'hFFFF_FFFC));
    tick_q.push_back(make_tick(1'b0, 32'h7FFF_FFFF, 32'h0, 32'h0));
    tick_q.push_back(make_tick(1'b1, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    wait_idle();

    // Zero reciprocal ratio and bottom values; writes to spare indexes are ignored.
    cfg_write(CFG_INVERSE_RATIO, 32'h8000_0000);
    cfg_write(CFG_SPRING_GAIN, 32'h0);
    cfg_write(CFG_DAMPING_GAIN, 32'h0001_0000);
    cfg_write(CFG_HALF_TIMESTEP, 32'hFFFF_0000);
    cfg_write(CFG_DIFF_MODE, 32'hFFFF_FFFE);
    for (int k = 0; k < 3; k++) begin
      cfg_write(3'(CfgIndexSpare + k), $urandom);
    end
    @(negedge clk);
    tick_q.push_back(make_tick(1'b1, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0));
    tick_q.push_back(make_tick(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h0));
    tick_q.push_back(make_tick(1'b1, 32'h1234_5678, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
    tick_q.push_back(make_tick(1'b0, 32'h0, 32'h0, 32'h0));
    wait_idle();

    // Random settings per phase, with random ticks and random handshake pressure.
    for (int p = 0; p < RandomPhases; p++) begin
      cfg_write(CFG_SPRING_GAIN, rand_gain());
      cfg_write(CFG_DAMPING_GAIN, rand_gain());
      cfg_write(CFG_INVERSE_RATIO, ($urandom_range(0, 5) == 0) ? 32'd1 : rand_gain());
      cfg_write(CFG_HALF_TIMESTEP, rand_half_step());
      cfg_write(CFG_DIFF_MODE, $urandom);
      if ($urandom_range(0, 1) == 0) begin
        cfg_write(3'(CfgIndexSpare + $urandom_range(0, 2)), $urandom);
      end
      @(negedge clk);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < TicksPerPhase; i++) begin
        tick_q.push_back(rand_tick());
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/dsdj_pkg.sv
sv/driveline_spring_damper_joint.sv
sv/dsdj_checker.sv
sim/testbench.sv
